[design/b64e_pkg.sv]
// Shared types, constants and the character map for the Base64 stream encoder.
package b64e_pkg;

	// Input transfer payload: one raw byte and its end-of-message mark.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// Output transfer payload: one ASCII character and its end-of-message mark.
	typedef struct packed {
		logic [6:0] out_char;
		logic       last_char;
	} out_item_t;

	// Characters produced by one input byte, as handed from front to back.
	typedef struct packed {
		logic [2:0]      count;
		logic [3:0][6:0] chars;
		logic            last;
	} group_t;

	localparam logic [6:0] ASCII_UPPER_A = 7'h41;
	localparam logic [6:0] ASCII_LOWER_A = 7'h61;
	localparam logic [6:0] ASCII_ZERO    = 7'h30;
	localparam logic [6:0] ASCII_PLUS    = 7'h2B;
	localparam logic [6:0] ASCII_SLASH   = 7'h2F;
	localparam logic [6:0] ASCII_PAD     = 7'h3D;

	// Maps a 6-bit value onto the standard Base64 alphabet.
	function automatic logic [6:0] b64_sym(input logic [5:0] v);
		logic [6:0] v7;
		v7 = {1'b0, v};
		if (v < 6'd26) begin
			return ASCII_UPPER_A + v7;
		end else if (v < 6'd52) begin
			return ASCII_LOWER_A + v7 - 7'd26;
		end else if (v < 6'd62) begin
			return ASCII_ZERO + v7 - 7'd52;
		end else if (v == 6'd62) begin
			return ASCII_PLUS;
		end else begin
			return ASCII_SLASH;
		end
	endfunction

endpackage

[design/base64_stream_encoder_top.sv]
// Top level of the Base64 stream encoder: front end, group queue and serializer.
//
// The encoder takes one raw byte per input transfer and sends one Base64 ASCII
// character per output transfer, padding the final group with '=' and marking
// the final character. An input byte is accepted in any cycle in which the
// group queue has room, so bytes may arrive back to back; each byte becomes
// one to four characters. The output serializer sends one character per
// cycle while the output port is ready, so the sustained input rate is set
// by that port: each three bytes of a message need four characters, and the
// flushed final byte up to four. A character passes through a queue entry,
// the current-group register and the output register on its way out.
module base64_stream_encoder_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  b64e_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output b64e_pkg::out_item_t out_data
);
	import b64e_pkg::*;

	logic   q_full;
	logic   q_push;
	logic   q_pop;
	logic   q_not_empty;
	group_t q_wdata;
	group_t q_rdata;

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_rdata)
	);

	b64e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

[design/b64e_front.sv]
// Front end: accepts bytes, tracks the group phase and builds each byte's characters.
module b64e_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  b64e_pkg::in_item_t in_data,
	input  logic              q_full,
	output logic              q_push,
	output b64e_pkg::group_t  q_data
);
	import b64e_pkg::*;

	localparam logic [1:0] PHASE_FIRST  = 2'd0;
	localparam logic [1:0] PHASE_SECOND = 2'd1;
	localparam logic [1:0] PHASE_THIRD  = 2'd2;

	logic [1:0] phase_q;
	logic [3:0] carry_q;
	logic [1:0] phase_d;
	logic [3:0] carry_d;
	logic [7:0] b;
	logic       last;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;
	assign b        = in_data.data_byte;
	assign last     = in_data.last_byte;

	// Build the characters for this byte and the next phase and carry.
	always_comb begin
		q_data.chars = {4{ASCII_PAD}};
		q_data.last  = last;
		q_data.count = 3'd1;
		case (phase_q)
			PHASE_SECOND: begin
				q_data.chars[0] = b64_sym({carry_q[1:0], b[7:4]});
				q_data.chars[1] = b64_sym({b[3:0], 2'b00});
				q_data.count    = last ? 3'd3 : 3'd1;
				phase_d         = PHASE_THIRD;
				carry_d         = b[3:0];
			end
			PHASE_THIRD: begin
				q_data.chars[0] = b64_sym({carry_q, b[7:6]});
				q_data.chars[1] = b64_sym(b[5:0]);
				q_data.count    = 3'd2;
				phase_d         = PHASE_FIRST;
				carry_d         = 4'd0;
			end
			default: begin
				q_data.chars[0] = b64_sym(b[7:2]);
				q_data.chars[1] = b64_sym({b[1:0], 4'b0000});
				q_data.count    = last ? 3'd4 : 3'd1;
				phase_d         = PHASE_SECOND;
				carry_d         = {2'b00, b[1:0]};
			end
		endcase
		if (last) begin
			phase_d = PHASE_FIRST;
			carry_d = 4'd0;
		end
	end

	// Group position and leftover bits advance on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_FIRST;
			carry_q <= 4'd0;
		end else if (q_push) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

endmodule

[design/b64e_queue.sv]
// Short queue of character groups between the front and back ends.
module b64e_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b64e_pkg::group_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output b64e_pkg::group_t pop_data
);
	import b64e_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	group_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/b64e_back.sv]
// Back end: serializes queued groups into one output character per cycle while the output is ready.
module b64e_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  b64e_pkg::group_t    q_data,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output b64e_pkg::out_item_t out_data
);
	import b64e_pkg::*;

	group_t    cur_q;
	logic      cur_valid_q;
	logic [1:0] idx_q;
	logic      out_valid_q;
	out_item_t out_data_q;
	logic      load_out;
	logic      cur_done;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The output register takes a character whenever a group is current and the register is empty or being drained.
	assign load_out = cur_valid_q && (!out_valid_q || out_ready);
	assign cur_done = load_out && ({1'b0, idx_q} == cur_q.count - 3'd1);
	assign q_pop    = q_not_empty && (!cur_valid_q || cur_done);

	// Current group, character index and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (cur_done) begin
				cur_valid_q <= 1'b0;
				idx_q       <= 2'd0;
			end else if (load_out) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (load_out) begin
			out_data_q.out_char  <= cur_q.chars[idx_q];
			out_data_q.last_char <= cur_done && cur_q.last;
		end
	end

endmodule

[dv/tb_base64_stream_encoder_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the Base64 stream encoder, with a built-in encoding predictor.
module tb_base64_stream_encoder_top;
	import b64e_pkg::*;

	localparam int RANDOM_BYTES = 236;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 20;

	// Standard alphabet, entry 0 in the top byte.
	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// A byte waiting to be sent; hold_for_idle makes the sender wait for an empty pipe.
	typedef struct {
		in_item_t item;
		bit       hold_for_idle;
	} pending_byte_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	pending_byte_t byte_q[$];
	out_item_t     char_q[$];

	// Encoder state tracked by the predictor.
	logic [1:0] enc_phase = 2'd0;
	logic [3:0] enc_carry = 4'd0;

	int err_count     = 0;
	int bytes_sent    = 0;
	int msgs_sent     = 0;
	int chars_checked = 0;
	int cycle_count   = 0;
	int ends_at_phase [3] = '{0, 0, 0};
	int send_gap      = 0;
	int recv_gap      = 0;
	bit send_burst    = 1'b0;
	bit recv_burst    = 1'b0;

	base64_stream_encoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Looks up the ASCII character for a 6-bit value.
	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [7:0] ch;
		ch = ALPHABET[8*(63 - int'(v)) +: 8];
		return ch[6:0];
	endfunction

	function automatic void push_char(input logic [6:0] ch, input logic is_last);
		out_item_t c;
		c.out_char  = ch;
		c.last_char = is_last;
		char_q.push_back(c);
	endfunction

	// Works out the characters that one accepted byte produces and advances the group state.
	function automatic void encode_byte(input in_item_t it);
		logic [7:0] b;
		b = it.data_byte;
		if (it.last_byte) begin
			ends_at_phase[(enc_phase == 2'd3) ? 0 : int'(enc_phase)]++;
		end
		case (enc_phase)
			2'd1: begin
				push_char(b64_char({enc_carry[1:0], b[7:4]}), 1'b0);
				if (it.last_byte) begin
					push_char(b64_char({b[3:0], 2'b00}), 1'b0);
					push_char(ASCII_PAD, 1'b1);
				end
				enc_carry = b[3:0];
				enc_phase = 2'd2;
			end
			2'd2: begin
				push_char(b64_char({enc_carry, b[7:6]}), 1'b0);
				push_char(b64_char(b[5:0]), it.last_byte);
				enc_carry = 4'd0;
				enc_phase = 2'd0;
			end
			default: begin
				push_char(b64_char(b[7:2]), 1'b0);
				if (it.last_byte) begin
					push_char(b64_char({b[1:0], 4'b0000}), 1'b0);
					push_char(ASCII_PAD, 1'b0);
					push_char(ASCII_PAD, 1'b1);
				end
				enc_carry = {2'b00, b[1:0]};
				enc_phase = 2'd1;
			end
		endcase
		// A marked byte closes the message, so the next one starts a fresh group.
		if (it.last_byte) begin
			enc_phase = 2'd0;
			enc_carry = 4'd0;
		end
	endfunction

	// Mostly short gaps, a few long ones, none at all during a burst stretch.
	function automatic int pick_gap(input bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else begin
			return $urandom_range(8, 40);
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic queue_byte(input logic [7:0] b, input bit is_last, input bit hold);
		pending_byte_t p;
		p.item.data_byte = b;
		p.item.last_byte = is_last;
		p.hold_for_idle  = hold;
		byte_q.push_back(p);
	endtask

	// Sender: presents queued bytes and feeds each accepted transfer to the predictor.
	always @(posedge clk) begin
		pending_byte_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				encode_byte(in_data);
				bytes_sent++;
				if (in_data.last_byte) begin
					msgs_sent++;
				end
				if ($urandom_range(0, 39) == 0) begin
					send_burst = !send_burst;
				end
				send_gap = pick_gap(send_burst);
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (byte_q.size() > 0 &&
					(!byte_q[0].hold_for_idle || char_q.size() == 0)) begin
					nxt = byte_q.pop_front();
					in_valid <= 1'b1;
					in_data  <= nxt.item;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each character transfer against the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (char_q.size() == 0) begin
					report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
						out_data.out_char, out_data.last_char));
				end else begin
					want = char_q.pop_front();
					chars_checked++;
					if (out_data.out_char !== want.out_char) begin
						report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
							out_data.out_char, want.out_char));
					end
					if (out_data.last_char !== want.last_char) begin
						report_mismatch($sformatf("last_char %0b, expected %0b on 0x%02h",
							out_data.last_char, want.last_char, want.out_char));
					end
				end
				if ($urandom_range(0, 39) == 0) begin
					recv_burst = !recv_burst;
				end
				recv_gap = pick_gap(recv_burst);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d bytes unsent, %0d characters outstanding.",
				cycle_count, byte_q.size(), char_q.size());
			$display("FAIL base64_stream_encoder_top");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		int      total;
		int      len;
		bit      hold;
		logic [7:0] b;

		// Directed messages: every end phase, all-zero and all-one bytes, '+' and '/'.
		queue_byte(8'h00, 1'b1, 1'b0);
		queue_byte(8'hFF, 1'b1, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b1);
		queue_byte(8'h00, 1'b1, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0);
		queue_byte(8'h80, 1'b1, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b1, 1'b0);
		queue_byte(8'h55, 1'b0, 1'b0);
		queue_byte(8'hAA, 1'b0, 1'b0);
		queue_byte(8'h0F, 1'b0, 1'b0);
		queue_byte(8'hF0, 1'b1, 1'b0);
		queue_byte(8'h4D, 1'b0, 1'b1);
		queue_byte(8'h61, 1'b0, 1'b0);
		queue_byte(8'h6E, 1'b0, 1'b0);
		queue_byte(8'h01, 1'b0, 1'b0);
		queue_byte(8'hFE, 1'b1, 1'b0);
		queue_byte(8'hFB, 1'b0, 1'b0);
		queue_byte(8'hEF, 1'b0, 1'b0);
		queue_byte(8'hBE, 1'b1, 1'b0);

		// Random messages, mostly short, now and then a long one.
		total = 0;
		while (total < RANDOM_BYTES) begin
			len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			hold = ($urandom_range(0, 7) == 0);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 9))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom_range(0, 255));
				endcase
				queue_byte(b, i == len - 1, hold && i == 0);
			end
			total += len;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (char_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d messages and checked %0d characters.",
			bytes_sent, msgs_sent, chars_checked);
		$display("Messages closed on group byte 1/2/3: %0d/%0d/%0d, with stalls on both ports.",
			ends_at_phase[0], ends_at_phase[1], ends_at_phase[2]);
		if (err_count == 0 && char_q.size() == 0) begin
			$display("PASS base64_stream_encoder_top");
		end else begin
			$display("FAIL base64_stream_encoder_top");
		end
		$finish;
	end

endmodule

[filelist.f]
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_queue.sv
design/b64e_back.sv
design/base64_stream_encoder_top.sv
dv/tb_base64_stream_encoder_top.sv
